FILE: sv/hccm_pkg.sv
// Shared types, constants and the sine table for the HSV cone colour matcher.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package hccm_pkg;

  // Reference table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  // Divider operand widths (hue and saturation numerators, 8-bit divisor)
  localparam int DIV_NUM_W = 17;
  localparam int DIV_DEN_W = 8;

  // Register stages in the distance unit
  localparam int DIST_STAGES = 6;

  localparam logic [23:0] THRESHOLD_RESET = 24'd500000;
  localparam logic [63:0] PI_Q30          = 64'd3373259426;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Point on the cone: x, y in Q14 scaled by v*s, plus value
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [7:0]         v;
  } point_t;

  typedef logic [14:0] sine_table_t [0:90];

  // Build the quarter-wave table from a Taylor series in Q30, rounded to Q14
  function automatic sine_table_t build_sine();
    sine_table_t t;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    for (int k = 0; k <= 90; k++) begin
      x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
      term = x;
      sum  = x;
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'd6;
      sum  = sum - term;
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'd20;
      sum  = sum + term;
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'd42;
      sum  = sum - term;
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'd72;
      sum  = sum + term;
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'd110;
      sum  = sum - term;
      t[k] = 15'((sum + 64'd32768) >> 16);
    end
    return t;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine();

  // Signed Q14 sine of a whole-degree angle 0..359
  function automatic logic signed [15:0] sine_deg(input logic [8:0] h);
    logic [6:0]  idx;
    logic        neg;
    logic [15:0] mag;
    if (h <= 9'd90) begin
      idx = 7'(h);
      neg = 1'b0;
    end else if (h <= 9'd180) begin
      idx = 7'(9'd180 - h);
      neg = 1'b0;
    end else if (h <= 9'd270) begin
      idx = 7'(h - 9'd180);
      neg = 1'b1;
    end else begin
      idx = 7'(9'd360 - h);
      neg = 1'b1;
    end
    mag = {1'b0, SINE_TABLE[idx]};
    return neg ? $signed(-mag) : $signed(mag);
  endfunction

endpackage

FILE: sv/hsv_cone_color_match.sv
// HSV cone colour matcher, top level.
// Clear or dropped append: straight to output. Append: 17-step divider plus two
// conversion stages. Query: conversion, 16 ring shifts, 6-stage distance pipe,
// output. One request at a time; the 17-step divider and the ring
// walk set the rate. Synchronous reset empties the table and sets threshold 500000.
`timescale 1ns / 1ps

module hsv_cone_color_match import hccm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        matched,
  output logic        status,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata
);

  state_t          state;
  state_t          state_next;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] scan_cnt;
  logic [2:0]       drain_cnt;
  logic             op_query;
  logic             res_status;
  logic             match_acc;

  logic             accept;
  logic             full;
  logic             pt_start;
  logic             pt_done;
  point_t           new_pt;
  logic             scan_en;
  logic             cell_wr;
  logic             out_load;
  logic             cmp_valid;
  logic             hit;
  logic [47:0]      thr_sq;

  point_t           cell_pt [TABLE_DEPTH];

  assign full = (count == CNT_W'(TABLE_DEPTH));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (kind)
            KIND_APPEND: state_next = full ? ST_DONE : ST_CONV;
            KIND_QUERY:  state_next = (count == '0) ? ST_DONE : ST_CONV;
            default:     state_next = ST_DONE;
          endcase
        end
      end
      ST_CONV: begin
        if (pt_done) state_next = op_query ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (scan_cnt == IDX_W'(TABLE_DEPTH - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_cnt == 3'(DIST_STAGES - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the state machine
  always_comb begin
    in_ready = (state == ST_IDLE);
    accept   = in_ready && in_valid;
    pt_start = accept && ((kind == KIND_APPEND && !full) ||
                          (kind == KIND_QUERY && count != '0));
    scan_en  = (state == ST_SCAN);
    cell_wr  = (state == ST_CONV) && pt_done && !op_query;
    out_load = (state == ST_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Table fill count and per-request bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      scan_cnt  <= '0;
      drain_cnt <= '0;
      match_acc <= 1'b0;
    end else begin
      if (accept) begin
        scan_cnt  <= '0;
        drain_cnt <= '0;
        match_acc <= 1'b0;
        if (kind == KIND_CLEAR) count <= '0;
      end
      if (cell_wr) count <= count + 1'b1;
      if (scan_en) scan_cnt <= scan_cnt + 1'b1;
      if (state == ST_DRAIN) drain_cnt <= drain_cnt + 1'b1;
      if (hit) match_acc <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_query   <= (kind == KIND_QUERY);
      res_status <= (kind == KIND_APPEND) && full;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      matched <= match_acc;
      status  <= res_status;
    end
  end

  hccm_unused_guard u_thr (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .thr_sq    (thr_sq)
  );

  hccm_point u_point (
    .clk   (clk),
    .rst   (rst),
    .start (pt_start),
    .red   (red),
    .green (green),
    .blue  (blue),
    .done  (pt_done),
    .pt    (new_pt)
  );

  // Ring of reference cells; cell zero feeds the distance unit
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    hccm_cell u_cell (
      .clk     (clk),
      .load    (cell_wr && count[IDX_W-1:0] == IDX_W'(i)),
      .load_pt (new_pt),
      .shift   (scan_en),
      .next_pt (cell_pt[(i + 1) % TABLE_DEPTH]),
      .pt      (cell_pt[i])
    );
  end

  assign cmp_valid = scan_en && ({1'b0, scan_cnt} < count);

  hccm_dist u_dist (
    .clk    (clk),
    .rst    (rst),
    .valid  (cmp_valid),
    .qpt    (new_pt),
    .rpt    (cell_pt[0]),
    .thr_sq (thr_sq),
    .hit    (hit)
  );

endmodule

FILE: sv/hccm_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on hccm_pkg for operand widths.
`timescale 1ns / 1ps

module hccm_div import hccm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] dividend,
  input  logic [DIV_DEN_W-1:0] divisor,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quotient
);

  localparam int CNT_DW = $clog2(DIV_NUM_W);

  logic                 busy;
  logic [CNT_DW-1:0]    cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   trial;
  logic                 take;

  // Trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, quotient[DIV_NUM_W-1]};
    take  = trial >= {1'b0, den};
  end

  // Control: count the steps, pulse done on the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_DW'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the dividend out and the quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      den      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DIV_NUM_W-2:0], take};
      rem      <= take ? DIV_DEN_W'(trial - {1'b0, den}) : trial[DIV_DEN_W-1:0];
    end
  end

endmodule

FILE: sv/hccm_point.sv
// Converts one RGB colour to integer HSV and then to a point on the cone.
// Depends on hccm_pkg and two hccm_div instances for hue and saturation.
`timescale 1ns / 1ps

module hccm_point import hccm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       done,
  output point_t     pt
);

  logic [7:0]           mx;
  logic [7:0]           mn;
  logic [7:0]           delta;
  logic signed [19:0]   hue_num;
  logic [DIV_NUM_W-1:0] hue_div;
  logic [DIV_NUM_W-1:0] sat_div;
  logic [DIV_NUM_W-1:0] hue_q;
  logic [DIV_NUM_W-1:0] sat_q;
  logic                 hue_done;
  logic                 sat_done;

  logic [7:0]           v_hold;
  logic                 grey;
  logic [8:0]           h;
  logic [7:0]           s;
  logic [8:0]           h_cos;

  logic                 trig_valid;
  logic [15:0]          vs;
  logic signed [15:0]   sin_q;
  logic signed [15:0]   cos_q;
  logic [7:0]           v_trig;
  logic signed [31:0]   vs_ext;

  // Max, min and the two numerators
  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
    delta = mx - mn;
    if (red == mx) begin
      hue_num = 20'sd60 * ($signed({12'd0, green}) - $signed({12'd0, blue}));
    end else if (green == mx) begin
      hue_num = 20'sd60 * ($signed({11'd0, delta, 1'b0}) + $signed({12'd0, blue})
                - $signed({12'd0, red}));
    end else begin
      hue_num = 20'sd60 * ($signed({10'd0, delta, 2'b0}) + $signed({12'd0, red})
                - $signed({12'd0, green}));
    end
    if (hue_num < 0) hue_num = hue_num + 20'sd360 * $signed({12'd0, delta});
    hue_div = DIV_NUM_W'(hue_num);
    sat_div = DIV_NUM_W'(17'd255 * {9'd0, delta} + {10'd0, mx[7:1]});
  end

  hccm_div u_hue_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (hue_div),
    .divisor  (delta),
    .done     (hue_done),
    .quotient (hue_q)
  );

  hccm_div u_sat_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (sat_div),
    .divisor  (mx),
    .done     (sat_done),
    .quotient (sat_q)
  );

  // Hold value and the grey flag while the dividers run
  always_ff @(posedge clk) begin
    if (start) begin
      v_hold <= mx;
      grey   <= (delta == 8'd0);
    end
  end

  // Grey colours have no hue and no saturation
  always_comb begin
    h     = grey ? 9'd0 : hue_q[8:0];
    s     = grey ? 8'd0 : sat_q[7:0];
    h_cos = (h >= 9'd270) ? h - 9'd270 : h + 9'd90;
  end

  // Control: two stages after the dividers finish
  always_ff @(posedge clk) begin
    if (rst) begin
      trig_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      trig_valid <= hue_done & sat_done;
      done       <= trig_valid;
    end
  end

  // Stage one: radius product and table lookups
  always_ff @(posedge clk) begin
    if (hue_done) begin
      vs     <= 16'(v_hold * s);
      sin_q  <= sine_deg(h);
      cos_q  <= sine_deg(h_cos);
      v_trig <= v_hold;
    end
  end

  assign vs_ext = 32'($signed({1'b0, vs}));

  // Stage two: cone coordinates
  always_ff @(posedge clk) begin
    if (trig_valid) begin
      pt.x <= 32'(vs_ext * 32'(cos_q));
      pt.y <= 32'(vs_ext * 32'(sin_q));
      pt.v <= v_trig;
    end
  end

endmodule

FILE: sv/hccm_cell.sv
// One slot of the reference ring: holds a stored cone point.
// Depends on hccm_pkg for the point type.
`timescale 1ns / 1ps

module hccm_cell import hccm_pkg::*; (
  input  logic   clk,
  input  logic   load,
  input  point_t load_pt,
  input  logic   shift,
  input  point_t next_pt,
  output point_t pt
);

  // Load a new reference or take the neighbour's point
  always_ff @(posedge clk) begin
    if (load) begin
      pt <= load_pt;
    end else if (shift) begin
      pt <= next_pt;
    end
  end

endmodule

FILE: sv/hccm_dist.sv
// Pipelined squared-distance test between a query point and one reference.
// Depends on hccm_pkg for the point type and DIST_STAGES.
`timescale 1ns / 1ps

module hccm_dist import hccm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  input  point_t      qpt,
  input  point_t      rpt,
  input  logic [47:0] thr_sq,
  output logic        hit
);

  logic [DIST_STAGES-1:0] vld;
  logic signed [32:0]     ex;
  logic signed [32:0]     ey;
  logic [31:0]            dx;
  logic [31:0]            dy;
  logic [7:0]             dv;
  logic [63:0]            dx2;
  logic [63:0]            dy2;
  logic [15:0]            dv2;
  logic [63:0]            w;
  logic [73:0]            part_a;
  logic [73:0]            part_b;
  logic [73:0]            lhs;
  logic [73:0]            rhs;
  logic                   close;

  assign ex = 33'(qpt.x) - 33'(rpt.x);
  assign ey = 33'(qpt.y) - 33'(rpt.y);

  // Advance the valid marks
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DIST_STAGES-2:0], valid};
    end
  end

  // Absolute differences, squares, sum, then 625 times the sum by shifts
  always_ff @(posedge clk) begin
    dx     <= ex[32] ? 32'(-ex) : 32'(ex);
    dy     <= ey[32] ? 32'(-ey) : 32'(ey);
    dv     <= (qpt.v >= rpt.v) ? qpt.v - rpt.v : rpt.v - qpt.v;
    dx2    <= 64'(dx) * 64'(dx);
    dy2    <= 64'(dy) * 64'(dy);
    dv2    <= 16'(dv * dv);
    w      <= dx2 + dy2 + ({46'd0, 18'(18'd3 * {2'd0, dv2})} << 28);
    part_a <= ({10'd0, w} << 9) + ({10'd0, w} << 6);
    part_b <= ({10'd0, w} << 5) + ({10'd0, w} << 4) + {10'd0, w};
    lhs    <= part_a + part_b;
    close  <= lhs < rhs;
  end

  assign rhs = {thr_sq, 26'd0};
  assign hit = vld[DIST_STAGES-1] & close;

endmodule

FILE: sv/hccm_unused_guard.sv
// Registered squaring of the match threshold for the distance unit.
// Depends on hccm_pkg for the reset value.
`timescale 1ns / 1ps

module hccm_unused_guard import hccm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  output logic [47:0] thr_sq
);

  logic [23:0] threshold;

  // Hold the threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  // Square the held threshold into a register of its own
  always_ff @(posedge clk) begin
    thr_sq <= 48'(threshold) * 48'(threshold);
  end

endmodule
